[rtl/core/timq_pkg.sv]
// Shared types and constants of the delta-list timer queue.
package timq_pkg;

	localparam int ID_W    = 8;
	localparam int DUR_W   = 16;
	localparam int COUNT_W = 5;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [DUR_W-1:0] delta;
	} entry_t;

endpackage

[rtl/core/timq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module timq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [WIDTH-1:0]               wr_data,
	input  logic [AW-1:0]                  rd_addr,
	output logic [WIDTH-1:0]               rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/delta_list_timer_queue.sv]
// Delta-list timer queue: ordered pending timers kept in one RAM, walked by a small sequencer.
//
// An item is taken when start is high and busy is low; its single result is shown
// for one cycle with done high and cannot be held off by the receiver. Busy rises
// the cycle after an item is taken and falls in the cycle done pulses. A set walks
// the pending list one RAM entry per cycle and shifts the later entries up by one on
// the same pass, then writes the last entry in S_TAIL before it answers; a tick that
// only decrements the head answers from S_HEAD, and one that expires the head shifts
// the rest down at one entry per cycle in S_DROP before it answers. A set to a full
// list or a tick on an empty list answers through S_RESP. The single RAM write
// port and its registered read port set this pace; the one subtractor does every
// delta update.
module delta_list_timer_queue #(
	parameter int MAX_TIMERS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [timq_pkg::ID_W-1:0]     timer_id,
	input  logic [timq_pkg::DUR_W-1:0]    duration,
	output logic                          done,
	output logic                          expired_valid,
	output logic [timq_pkg::ID_W-1:0]     expired_id,
	output logic                          set_rejected,
	output logic [timq_pkg::COUNT_W-1:0]  pending_count
);

	import timq_pkg::*;

	localparam int CW = $clog2(MAX_TIMERS + 1);
	localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_TAIL,
		S_HEAD,
		S_DROP,
		S_RESP
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    proc_q;
	logic [DUR_W-1:0] rem_q;
	logic [ID_W-1:0]  id_q;
	entry_t           carry_q;
	logic             ins_q;
	logic             fix_q;
	logic             done_q;
	logic             expired_valid_q;
	logic [ID_W-1:0]  expired_id_q;
	logic             set_rejected_q;

	entry_t           rd_data;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	entry_t           wr_data;
	logic [AW-1:0]    rd_addr;

	logic [DUR_W-1:0] alu_a;
	logic [DUR_W-1:0] alu_b;
	logic [DUR_W:0]   alu_diff;
	entry_t           carry_out;
	logic             walk_last;
	logic             drop_last;

	timq_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_TIMERS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Shared subtractor: borrow in the top bit
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		unique case (state_q)
			S_WALK: begin
				if (ins_q) begin
					alu_a = carry_q.delta;
					alu_b = rem_q;
				end else begin
					alu_a = rem_q;
					alu_b = rd_data.delta;
				end
			end
			S_TAIL: begin
				alu_a = carry_q.delta;
				alu_b = rem_q;
			end
			S_HEAD: begin
				alu_a = rd_data.delta;
				alu_b = DUR_W'(1);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};

	// Displaced entry; the one right after the new timer gives up the new timer's delta
	always_comb begin
		carry_out.id    = carry_q.id;
		carry_out.delta = fix_q ? alu_diff[DUR_W-1:0] : carry_q.delta;
	end

	assign walk_last = (proc_q == count_q - CW'(1));
	assign drop_last = (proc_q == count_q - CW'(2));

	// RAM port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(proc_q);
		wr_data = rd_data;
		rd_addr = '0;
		unique case (state_q)
			S_WALK: begin
				rd_addr = AW'(proc_q + CW'(1));
				if (ins_q) begin
					wr_en   = 1'b1;
					wr_data = carry_out;
				end else if (alu_diff[DUR_W]) begin
					wr_en         = 1'b1;
					wr_data.id    = id_q;
					wr_data.delta = rem_q;
				end
			end
			S_TAIL: begin
				wr_en   = 1'b1;
				wr_addr = AW'(count_q);
				if (ins_q) begin
					wr_data = carry_out;
				end else begin
					wr_data.id    = id_q;
					wr_data.delta = rem_q;
				end
			end
			S_HEAD: begin
				rd_addr = AW'(1);
				if (rd_data.delta != '0) begin
					wr_en         = 1'b1;
					wr_addr       = '0;
					wr_data.id    = rd_data.id;
					wr_data.delta = alu_diff[DUR_W-1:0];
				end
			end
			S_DROP: begin
				rd_addr = AW'(proc_q + CW'(2));
				wr_en   = 1'b1;
				wr_data = rd_data;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			proc_q          <= '0;
			rem_q           <= '0;
			id_q            <= '0;
			carry_q         <= '0;
			done_q          <= 1'b0;
			ins_q           <= 1'b0;
			fix_q           <= 1'b0;
			expired_valid_q <= 1'b0;
			expired_id_q    <= '0;
			set_rejected_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						expired_valid_q <= 1'b0;
						expired_id_q    <= '0;
						set_rejected_q  <= 1'b0;
						rem_q           <= duration;
						id_q            <= timer_id;
						proc_q          <= '0;
						ins_q           <= 1'b0;
						fix_q           <= 1'b0;
						if (req_type == REQ_SET) begin
							if (count_q == CW'(MAX_TIMERS)) begin
								set_rejected_q <= 1'b1;
								state_q        <= S_RESP;
							end else if (count_q == '0) begin
								state_q <= S_TAIL;
							end else begin
								state_q <= S_WALK;
							end
						end else begin
							state_q <= (count_q == '0) ? S_RESP : S_HEAD;
						end
					end
				end
				S_WALK: begin
					if (ins_q) begin
						carry_q <= rd_data;
						fix_q   <= 1'b0;
					end else if (alu_diff[DUR_W]) begin
						// new timer lands here; hold the old entry to push it up
						carry_q <= rd_data;
						fix_q   <= 1'b1;
						ins_q   <= 1'b1;
					end else begin
						rem_q <= alu_diff[DUR_W-1:0];
					end
					proc_q <= proc_q + CW'(1);
					if (walk_last) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					count_q <= count_q + CW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_HEAD: begin
					if (rd_data.delta != '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						expired_valid_q <= 1'b1;
						expired_id_q    <= rd_data.id;
						if (count_q == CW'(1)) begin
							count_q <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_DROP;
						end
					end
				end
				S_DROP: begin
					proc_q <= proc_q + CW'(1);
					if (drop_last) begin
						count_q <= count_q - CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign expired_valid = expired_valid_q;
	assign expired_id    = expired_id_q;
	assign set_rejected  = set_rejected_q;
	assign pending_count = COUNT_W'(count_q);

endmodule

[rtl/core/timq_chk.sv]
// Port-level checker for the timer queue, bound to the top level.
module timq_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic expired_valid,
	input logic set_rejected
);

	// An accepted item always occupies the sequencer, raising busy in the cycle after it is taken
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && expired_valid |-> !set_rejected)
		else $error("expiry and rejection in one result");

endmodule

bind delta_list_timer_queue timq_chk u_timq_chk (.*);
